/* rtl/xvbc_pkg.sv */
// ----------------------------------------------------------------------------
// xvbc_pkg
// shared types, constants and helpers for the xtea-style block cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xvbc_pkg;

  localparam int unsigned WordW          = 32;
  localparam int unsigned KeyWords       = 4;
  localparam int unsigned KeyIdxW        = 2;
  localparam int unsigned RoundCountDef  = 32;
  localparam logic [WordW-1:0] Delta     = 32'h9e37_79b9;

  // configuration register indexes
  localparam logic [KeyIdxW-1:0] KEY_WORD0_IDX = 2'd0;
  localparam logic [KeyIdxW-1:0] KEY_WORD1_IDX = 2'd1;
  localparam logic [KeyIdxW-1:0] KEY_WORD2_IDX = 2'd2;
  localparam logic [KeyIdxW-1:0] KEY_WORD3_IDX = 2'd3;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             decrypt;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
  } blk_t;

  // k * delta modulo 2^32, only ever evaluated on constants
  function automatic logic [WordW-1:0] delta_mult(input int unsigned k);
    logic [2*WordW-1:0] prod;
    prod = (2*WordW)'(k) * (2*WordW)'(Delta);
    return prod[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/xvbc_round_stage.sv */
// ----------------------------------------------------------------------------
// xvbc_round_stage
// one registered half-round of the cipher, encrypt or decrypt per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xvbc_round_stage #(
  parameter int unsigned ROUND_COUNT = xvbc_pkg::RoundCountDef,
  parameter int unsigned STAGE_IDX   = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire xvbc_pkg::key_t key_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire xvbc_pkg::blk_t in_blk_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output xvbc_pkg::blk_t      out_blk_o
);

  localparam int unsigned Round      = STAGE_IDX / 2;
  localparam bit          SecondHalf = (STAGE_IDX % 2) == 1;

  localparam logic [xvbc_pkg::WordW-1:0] EncSum = SecondHalf ?
      xvbc_pkg::delta_mult(Round + 1) : xvbc_pkg::delta_mult(Round);
  localparam logic [xvbc_pkg::WordW-1:0] DecSum = SecondHalf ?
      xvbc_pkg::delta_mult(ROUND_COUNT - Round - 1) :
      xvbc_pkg::delta_mult(ROUND_COUNT - Round);

  // y updates take key[sum & 3], z updates key[(sum >> 11) & 3]
  localparam logic [xvbc_pkg::KeyIdxW-1:0] EncKeySel =
      SecondHalf ? EncSum[12:11] : EncSum[1:0];
  localparam logic [xvbc_pkg::KeyIdxW-1:0] DecKeySel =
      SecondHalf ? DecSum[1:0] : DecSum[12:11];

  logic                          valid_q, valid_d;
  xvbc_pkg::blk_t                blk_q, blk_d;
  logic                          load;
  logic                          upd_y;
  logic [xvbc_pkg::WordW-1:0]    src, tgt, sum, keyw, shx, mix, res;

  always_comb begin
    // encrypt updates y on the first half, decrypt on the second
    upd_y = (in_blk_i.decrypt == SecondHalf);
    src   = upd_y ? in_blk_i.z : in_blk_i.y;
    tgt   = upd_y ? in_blk_i.y : in_blk_i.z;
    sum   = in_blk_i.decrypt ? DecSum : EncSum;
    keyw  = key_i[in_blk_i.decrypt ? DecKeySel : EncKeySel];
    shx   = {src[xvbc_pkg::WordW-5:0], 4'b0000}
            ^ {{5{src[xvbc_pkg::WordW-1]}}, src[xvbc_pkg::WordW-1:5]};
    mix   = shx + (src ^ sum) + keyw;
    res   = in_blk_i.decrypt ? (tgt - mix) : (tgt + mix);

    blk_d         = in_blk_i;
    if (upd_y) begin
      blk_d.y = res;
    end else begin
      blk_d.z = res;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_ready_o && in_valid_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_blk_o   = blk_q;

endmodule

`default_nettype wire

/* rtl/xtea_variant_block_cipher.sv */
// ----------------------------------------------------------------------------
// xtea_variant_block_cipher
// xtea-style 64-bit block cipher, 128-bit key, fully unrolled pipeline
// ----------------------------------------------------------------------------
// channel   direction  fields
// s_axis    in         tdata: first_half, second_half; tuser: action
// m_axis    out        tdata: out_first_half, out_second_half
// cfg       in         key_word0 .. key_word3 by index 0 .. 3
//
// one registered half-round per stage;
// one block enters and one leaves per cycle when not stalled.
// each stage holds its own valid bit, so bubbles close up under a stall and
// a new block is taken while a finished one waits, as long as a stage is empty.
// reset clears the valid bits and the key words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xtea_variant_block_cipher #(
  parameter int unsigned ROUND_COUNT = xvbc_pkg::RoundCountDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [xvbc_pkg::KeyIdxW-1:0]      cfg_idx_i,
  input  wire logic [xvbc_pkg::WordW-1:0]        cfg_wdata_i,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [2*xvbc_pkg::WordW-1:0]      s_axis_tdata,  // first_half, second_half
  input  wire logic [0:0]                        s_axis_tuser,  // action
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [2*xvbc_pkg::WordW-1:0]           m_axis_tdata   // out_first_half, out_second_half
);

  localparam int unsigned StageCount = 2 * ROUND_COUNT;
  localparam int unsigned W          = xvbc_pkg::WordW;

  xvbc_pkg::key_t  key_q;
  logic [StageCount:0] vld;
  logic [StageCount:0] rdy;
  xvbc_pkg::blk_t      blk [StageCount+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xvbc_pkg::KEY_WORD0_IDX: key_q[0] <= cfg_wdata_i;
        xvbc_pkg::KEY_WORD1_IDX: key_q[1] <= cfg_wdata_i;
        xvbc_pkg::KEY_WORD2_IDX: key_q[2] <= cfg_wdata_i;
        xvbc_pkg::KEY_WORD3_IDX: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign vld[0]         = s_axis_tvalid;
  assign blk[0].decrypt = s_axis_tuser[0];
  assign blk[0].y       = s_axis_tdata[W-1:0];
  assign blk[0].z       = s_axis_tdata[2*W-1:W];
  assign s_axis_tready  = rdy[0];

  for (genvar s = 0; s < StageCount; s++) begin : g_stage
    xvbc_round_stage #(
      .ROUND_COUNT (ROUND_COUNT),
      .STAGE_IDX   (s)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .key_i       (key_q),
      .in_valid_i  (vld[s]),
      .in_ready_o  (rdy[s]),
      .in_blk_i    (blk[s]),
      .out_valid_o (vld[s+1]),
      .out_ready_i (rdy[s+1]),
      .out_blk_o   (blk[s+1])
    );
  end

  assign rdy[StageCount] = m_axis_tready;
  assign m_axis_tvalid   = vld[StageCount];
  assign m_axis_tdata    = {blk[StageCount].z, blk[StageCount].y};

`ifndef SYNTHESIS
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // an empty output stage means the whole ready chain is open
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // blocks in flight change only by accepted requests on either side
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld[StageCount:1]) ==
       $countones($past(vld[StageCount:1])) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy mismatch");
`endif

endmodule

`default_nettype wire

/* dv/xtea_variant_block_cipher_test.sv */
// ----------------------------------------------------------------------------
// xtea_variant_block_cipher_test
// self-checking bench for the xtea-style block cipher pipeline
// ----------------------------------------------------------------------------
// blocks pushed on the input stream, results drawn from the output stream
// both streams stall at random, except through one key where they run flat out
// each accepted request ciphered by a behavioral copy of the rounds
// each result compared with the oldest expected block
// key words change only while the pipeline is empty
// keys: zeros from reset, all ones, mixed extremes, random, then zeros again
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea_variant_block_cipher_test;

  localparam int unsigned      WordW          = xvbc_pkg::WordW;
  localparam int unsigned      KeyWords       = xvbc_pkg::KeyWords;
  localparam int unsigned      KeyIdxW        = xvbc_pkg::KeyIdxW;
  localparam logic [WordW-1:0] Delta          = xvbc_pkg::Delta;
  localparam int unsigned      Rounds         = xvbc_pkg::RoundCountDef;
  localparam int unsigned      BlocksPerPhase = 186;
  localparam int unsigned      StallLimit     = 4000;
  localparam int unsigned      DrainCycles    = 2*Rounds + 8;
  localparam int unsigned      IdlePercent    = 14;

  typedef struct packed {
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
  } halves_t;

  // holds the key copy and the blocks still owed by the pipeline
  class block_ledger;
    logic [WordW-1:0] key_words [KeyWords];
    halves_t          owed_q[$];
    int unsigned      mismatches;
    int unsigned      blocks;
    int unsigned      decrypts;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      mismatches = 0;
      blocks     = 0;
      decrypts   = 0;
    endfunction

    function void set_key(logic [KeyIdxW-1:0] idx, logic [WordW-1:0] value);
      key_words[idx] = value;
    endfunction

    // arithmetic shift keeps the sign bit, as with signed halves
    function logic [WordW-1:0] round_mix(logic [WordW-1:0] x, sum, keyw);
      return ((x << 4) ^ {{5{x[WordW-1]}}, x[WordW-1:5]}) + (x ^ sum) + keyw;
    endfunction

    function void note_request(logic decrypt, logic [WordW-1:0] y_in, z_in);
      logic [WordW-1:0] y;
      logic [WordW-1:0] z;
      logic [WordW-1:0] sum;
      halves_t          res;
      int               r;
      y = y_in;
      z = z_in;
      if (!decrypt) begin
        sum = '0;
        for (r = 0; r < Rounds; r++) begin
          y   = y + round_mix(z, sum, key_words[sum[1:0]]);
          sum = sum + Delta;
          z   = z + round_mix(y, sum, key_words[sum[12:11]]);
        end
      end else begin
        sum = Rounds * Delta;
        for (r = 0; r < Rounds; r++) begin
          z   = z - round_mix(y, sum, key_words[sum[12:11]]);
          sum = sum - Delta;
          y   = y - round_mix(z, sum, key_words[sum[1:0]]);
        end
        decrypts++;
      end
      res.y = y;
      res.z = z;
      owed_q.push_back(res);
      blocks++;
    endfunction

    function void check_result(logic [2*WordW-1:0] data);
      halves_t want;
      if (owed_q.size() == 0) begin
        $error("result %h arrived with no request outstanding", data);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (data[WordW-1:0] !== want.y) begin
        $error("out_first_half: expected %h, actual %h", want.y, data[WordW-1:0]);
        mismatches++;
      end
      if (data[2*WordW-1:WordW] !== want.z) begin
        $error("out_second_half: expected %h, actual %h", want.z, data[2*WordW-1:WordW]);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [KeyIdxW-1:0]   cfg_idx_i     = xvbc_pkg::KEY_WORD0_IDX;
  logic [WordW-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*WordW-1:0]   s_axis_tdata  = '0;  // first_half, second_half
  logic [0:0]           s_axis_tuser  = '0;  // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*WordW-1:0]   m_axis_tdata;        // out_first_half, out_second_half

  logic                 steady        = 1'b0;
  int unsigned          quiet_cycles  = 0;
  int unsigned          key_settings  = 1;
  block_ledger          book          = new();

  xtea_variant_block_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check what was taken at this edge, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        book.check_result(m_axis_tdata);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_block(input logic decrypt, input logic [WordW-1:0] y, z);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y};
    s_axis_tuser  <= decrypt;
    do @(posedge clk_i); while (!s_axis_tready);
    book.note_request(decrypt, y, z);
  endtask

  task automatic write_keys(input logic [WordW-1:0] k0, k1, k2, k3);
    logic [WordW-1:0]   words [KeyWords];
    logic [KeyIdxW-1:0] idx   [KeyWords];
    int                 i;
    words = '{k0, k1, k2, k3};
    idx   = '{xvbc_pkg::KEY_WORD0_IDX, xvbc_pkg::KEY_WORD1_IDX,
              xvbc_pkg::KEY_WORD2_IDX, xvbc_pkg::KEY_WORD3_IDX};
    for (i = 0; i < KeyWords; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= words[i];
      @(posedge clk_i);
      book.set_key(idx[i], words[i]);
    end
    cfg_we_i <= 1'b0;
    key_settings++;
  endtask

  // pipeline is empty once nothing is owed, since every block yields one result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_corner_blocks();
    logic [WordW-1:0] firsts  [6] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                                      32'h7fff_ffff, 32'h0000_0001, 32'h9e37_79b9};
    logic [WordW-1:0] seconds [6] = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                                      32'h8000_0000, 32'hfff8_0000, 32'h0000_001f};
    int               i;
    for (i = 0; i < 6; i++) begin
      send_block(1'b0, firsts[i], seconds[i]);
      send_block(1'b1, firsts[i], seconds[i]);
    end
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random_blocks(input int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      send_block(1'($urandom_range(1)), pick_word(), pick_word());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keys still zero from reset
    run_corner_blocks();
    wait_drained();

    write_keys(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_corner_blocks();
    run_random_blocks(BlocksPerPhase);
    wait_drained();

    // no stalls on either side through this key
    write_keys(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    steady <= 1'b1;
    run_random_blocks(BlocksPerPhase);
    wait_drained();
    steady <= 1'b0;

    write_keys($urandom(), $urandom(), $urandom(), $urandom());
    run_random_blocks(BlocksPerPhase);
    wait_drained();

    write_keys($urandom(), $urandom(), $urandom(), $urandom());
    run_random_blocks(BlocksPerPhase);
    wait_drained();

    write_keys(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    run_random_blocks(BlocksPerPhase);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);

    $display("ciphered %0d blocks (%0d decrypt) under %0d keys",
             book.blocks, book.decrypts, key_settings);
    $display("corner words, random stalls on both streams and one stall-free stretch");
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/xvbc_pkg.sv
rtl/xvbc_round_stage.sv
rtl/xtea_variant_block_cipher.sv
dv/xtea_variant_block_cipher_test.sv
